FILE: hdl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg - shared types and constants of the source token lexer
// scan mode codes, token kinds and the keyword table
// ----------------------------------------------------------------------------
package stl_pkg;

	localparam logic [3:0] MD_IDLE   = 4'd0;
	localparam logic [3:0] MD_WORD   = 4'd1;
	localparam logic [3:0] MD_NUM    = 4'd2;
	localparam logic [3:0] MD_STR    = 4'd3;
	localparam logic [3:0] MD_CHOPEN = 4'd4;
	localparam logic [3:0] MD_CHGOT  = 4'd5;
	localparam logic [3:0] MD_EQ     = 4'd6;
	localparam logic [3:0] MD_BANG   = 4'd7;
	localparam logic [3:0] MD_LT     = 4'd8;
	localparam logic [3:0] MD_GT     = 4'd9;
	localparam logic [3:0] MD_AMP    = 4'd10;
	localparam logic [3:0] MD_BAR    = 4'd11;
	localparam logic [3:0] MD_STOP   = 4'd12;

	localparam logic [5:0] K_IDENT = 6'd0;
	localparam logic [5:0] K_INT   = 6'd11;
	localparam logic [5:0] K_DEC   = 6'd12;
	localparam logic [5:0] K_STR   = 6'd13;
	localparam logic [5:0] K_CHR   = 6'd14;
	localparam logic [5:0] K_PLUS  = 6'd15;
	localparam logic [5:0] K_MINUS = 6'd16;
	localparam logic [5:0] K_STAR  = 6'd17;
	localparam logic [5:0] K_SLASH = 6'd18;
	localparam logic [5:0] K_PCT   = 6'd19;
	localparam logic [5:0] K_ASSIGN = 6'd20;
	localparam logic [5:0] K_EQEQ  = 6'd21;
	localparam logic [5:0] K_NOT   = 6'd22;
	localparam logic [5:0] K_NE    = 6'd23;
	localparam logic [5:0] K_LT    = 6'd24;
	localparam logic [5:0] K_LE    = 6'd25;
	localparam logic [5:0] K_SHL   = 6'd26;
	localparam logic [5:0] K_GT    = 6'd27;
	localparam logic [5:0] K_GE    = 6'd28;
	localparam logic [5:0] K_ANDAND = 6'd29;
	localparam logic [5:0] K_OROR  = 6'd30;
	localparam logic [5:0] K_LPAR  = 6'd31;
	localparam logic [5:0] K_RPAR  = 6'd32;
	localparam logic [5:0] K_LBR   = 6'd33;
	localparam logic [5:0] K_RBR   = 6'd34;
	localparam logic [5:0] K_SEMI  = 6'd35;
	localparam logic [5:0] K_UNK   = 6'd36;
	localparam logic [5:0] K_EOF   = 6'd37;

	localparam int NUM_KW = 10;

	typedef logic [47:0] kw_win_t;

	// keyword text packed with the first byte highest, as shifted in
	localparam kw_win_t KW_TABLE [NUM_KW] = '{
		48'h6D656F77, 48'h696E74, 48'h64656369, 48'h626F6F6C, 48'h63686172,
		48'h737472696E67, 48'h74727565, 48'h66616C7365, 48'h6966, 48'h656C7365
	};

	// token record without line and position, which the datapath fills in
	typedef struct packed {
		logic       vld;
		logic [5:0] kind;
		logic       at_pend;   // start from pending_start, else current position
		logic       len_span;  // length from span, else len_small
		logic [1:0] len_small;
	} tok_ctl_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic [5:0] word_kind(input kw_win_t w, input logic too_long);
		logic [5:0] k;
		k = K_IDENT;
		if (!too_long)
			for (int i = 0; i < NUM_KW; i++)
				if (w == KW_TABLE[i]) k = 6'(i + 1);
		return k;
	endfunction

endpackage

FILE: hdl/stl_skid.sv
// ----------------------------------------------------------------------------
// stl_skid - two-entry result buffer
// holds the words of one byte step; the input side waits until it has space
// ----------------------------------------------------------------------------
module stl_skid #(
	parameter int W = 80
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_vld,
	input  logic [1:0]   in_cnt,
	input  logic [W-1:0] in_w0,
	input  logic [W-1:0] in_w1,
	output logic         space,
	output logic         out_vld,
	input  logic         out_rdy,
	output logic [W-1:0] out_w
);
	logic [1:0]   cnt_q;
	logic [W-1:0] b0_q, b1_q;
	logic         pop;

	assign out_vld = cnt_q != 2'd0;
	assign out_w   = b0_q;
	assign pop     = out_vld && out_rdy;
	// free when empty, or when the last held word leaves now
	assign space   = cnt_q == 2'd0 || (cnt_q == 2'd1 && out_rdy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_vld && in_cnt != 2'd0) begin
			cnt_q <= in_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld && in_cnt != 2'd0) begin
			b0_q <= in_w0;
			b1_q <= in_w1;
		end else if (pop) begin
			b0_q <= b1_q;
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("skid count out of range");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_vld && in_cnt != 2'd0) |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_rdy)))
		else $error("skid overwritten");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !(in_vld && in_cnt != 2'd0) && cnt_q == 2'd2) |=> cnt_q == 2'd1)
		else $error("skid pop lost");
`endif

endmodule

FILE: hdl/stl_scan.sv
// ----------------------------------------------------------------------------
// stl_scan - per-byte token decision
// pending-token close and fresh-byte start, purely combinational
// ----------------------------------------------------------------------------
module stl_scan (
	input  logic [3:0]          mode,
	input  logic [7:0]          b,
	input  stl_pkg::kw_win_t    win,
	input  logic                too_long,
	input  logic                dot,
	output stl_pkg::tok_ctl_t   t0,
	output stl_pkg::tok_ctl_t   t1,
	output logic [3:0]          mode_nx,
	output logic                line_inc,
	output logic                set_pend,
	output logic                pend_plus1,
	output stl_pkg::kw_win_t    win_nx,
	output logic                too_long_nx,
	output logic                dot_nx
);
	logic consumed;
	stl_pkg::tok_ctl_t tp, tf;

	function automatic stl_pkg::tok_ctl_t mk(input logic [5:0] k, input logic ap,
			input logic ls, input logic [1:0] l);
		stl_pkg::tok_ctl_t t;
		t.vld = 1'b1; t.kind = k; t.at_pend = ap; t.len_span = ls; t.len_small = l;
		return t;
	endfunction

	always_comb begin
		tp = '0; tf = '0;
		consumed = 1'b0;
		mode_nx = stl_pkg::MD_IDLE;
		line_inc = 1'b0; set_pend = 1'b0; pend_plus1 = 1'b0;
		win_nx = win; too_long_nx = too_long; dot_nx = dot;
		// close or extend the pending token
		case (mode)
			stl_pkg::MD_WORD: begin
				if (stl_pkg::is_alpha(b) || stl_pkg::is_digit(b) || b == 8'h5F) begin
					if (win[47:40] != 8'd0) too_long_nx = 1'b1;
					else win_nx = {win[39:0], b};
					mode_nx = stl_pkg::MD_WORD; consumed = 1'b1;
				end else tp = mk(stl_pkg::word_kind(win, too_long), 1'b1, 1'b1, 2'd0);
			end
			stl_pkg::MD_NUM: begin
				if (stl_pkg::is_digit(b) || (b == 8'h2E && !dot)) begin
					if (b == 8'h2E) dot_nx = 1'b1;
					mode_nx = stl_pkg::MD_NUM; consumed = 1'b1;
				end else tp = mk(dot ? stl_pkg::K_DEC : stl_pkg::K_INT, 1'b1, 1'b1, 2'd0);
			end
			stl_pkg::MD_STR: begin
				if (b == 8'h22) begin
					tp = mk(stl_pkg::K_STR, 1'b1, 1'b1, 2'd0); consumed = 1'b1;
				end else if (b == 8'd0) begin
					tp = mk(stl_pkg::K_STR, 1'b1, 1'b1, 2'd0);
				end else begin
					line_inc = b == 8'd10;
					mode_nx = stl_pkg::MD_STR; consumed = 1'b1;
				end
			end
			stl_pkg::MD_CHOPEN: begin
				if (b == 8'd10 || b == 8'd0) tp = mk(stl_pkg::K_CHR, 1'b1, 1'b0, 2'd0);
				else begin
					mode_nx = stl_pkg::MD_CHGOT; consumed = 1'b1;
				end
			end
			stl_pkg::MD_CHGOT: begin
				tp = mk(stl_pkg::K_CHR, 1'b1, 1'b0, 2'd1); consumed = b == 8'h27;
			end
			stl_pkg::MD_EQ: begin
				consumed = b == 8'h3D;
				tp = consumed ? mk(stl_pkg::K_EQEQ, 1'b1, 1'b0, 2'd2)
				              : mk(stl_pkg::K_ASSIGN, 1'b1, 1'b0, 2'd1);
			end
			stl_pkg::MD_BANG: begin
				consumed = b == 8'h3D;
				tp = consumed ? mk(stl_pkg::K_NE, 1'b1, 1'b0, 2'd2)
				              : mk(stl_pkg::K_NOT, 1'b1, 1'b0, 2'd1);
			end
			stl_pkg::MD_LT: begin
				consumed = b == 8'h3C || b == 8'h3D;
				if (b == 8'h3C) tp = mk(stl_pkg::K_SHL, 1'b1, 1'b0, 2'd2);
				else if (b == 8'h3D) tp = mk(stl_pkg::K_LE, 1'b1, 1'b0, 2'd2);
				else tp = mk(stl_pkg::K_LT, 1'b1, 1'b0, 2'd1);
			end
			stl_pkg::MD_GT: begin
				consumed = b == 8'h3D;
				tp = consumed ? mk(stl_pkg::K_GE, 1'b1, 1'b0, 2'd2)
				              : mk(stl_pkg::K_GT, 1'b1, 1'b0, 2'd1);
			end
			stl_pkg::MD_AMP: begin
				consumed = b == 8'h26;
				tp = consumed ? mk(stl_pkg::K_ANDAND, 1'b1, 1'b0, 2'd2)
				              : mk(stl_pkg::K_UNK, 1'b1, 1'b0, 2'd1);
			end
			stl_pkg::MD_BAR: begin
				consumed = b == 8'h7C;
				tp = consumed ? mk(stl_pkg::K_OROR, 1'b1, 1'b0, 2'd2)
				              : mk(stl_pkg::K_UNK, 1'b1, 1'b0, 2'd1);
			end
			default: ;
		endcase
		// byte not taken by a pending token starts afresh
		if (!consumed) begin
			case (b)
				8'd0: begin
					tf = mk(stl_pkg::K_EOF, 1'b0, 1'b0, 2'd0); mode_nx = stl_pkg::MD_STOP;
				end
				8'd10: line_inc = 1'b1;
				8'd9, 8'd11, 8'd12, 8'd13, 8'd32: ;
				8'h2B: tf = mk(stl_pkg::K_PLUS, 1'b0, 1'b0, 2'd1);
				8'h2D: tf = mk(stl_pkg::K_MINUS, 1'b0, 1'b0, 2'd1);
				8'h2A: tf = mk(stl_pkg::K_STAR, 1'b0, 1'b0, 2'd1);
				8'h2F: tf = mk(stl_pkg::K_SLASH, 1'b0, 1'b0, 2'd1);
				8'h25: tf = mk(stl_pkg::K_PCT, 1'b0, 1'b0, 2'd1);
				8'h28: tf = mk(stl_pkg::K_LPAR, 1'b0, 1'b0, 2'd1);
				8'h29: tf = mk(stl_pkg::K_RPAR, 1'b0, 1'b0, 2'd1);
				8'h7B: tf = mk(stl_pkg::K_LBR, 1'b0, 1'b0, 2'd1);
				8'h7D: tf = mk(stl_pkg::K_RBR, 1'b0, 1'b0, 2'd1);
				8'h3B: tf = mk(stl_pkg::K_SEMI, 1'b0, 1'b0, 2'd1);
				8'h3D: begin mode_nx = stl_pkg::MD_EQ; set_pend = 1'b1; end
				8'h21: begin mode_nx = stl_pkg::MD_BANG; set_pend = 1'b1; end
				8'h3C: begin mode_nx = stl_pkg::MD_LT; set_pend = 1'b1; end
				8'h3E: begin mode_nx = stl_pkg::MD_GT; set_pend = 1'b1; end
				8'h26: begin mode_nx = stl_pkg::MD_AMP; set_pend = 1'b1; end
				8'h7C: begin mode_nx = stl_pkg::MD_BAR; set_pend = 1'b1; end
				8'h22: begin
					mode_nx = stl_pkg::MD_STR; set_pend = 1'b1; pend_plus1 = 1'b1;
				end
				8'h27: begin
					mode_nx = stl_pkg::MD_CHOPEN; set_pend = 1'b1; pend_plus1 = 1'b1;
				end
				default: begin
					if (stl_pkg::is_alpha(b) || b == 8'h5F) begin
						mode_nx = stl_pkg::MD_WORD; set_pend = 1'b1;
						win_nx = {40'd0, b}; too_long_nx = 1'b0;
					end else if (stl_pkg::is_digit(b)) begin
						mode_nx = stl_pkg::MD_NUM; set_pend = 1'b1; dot_nx = 1'b0;
					end else tf = mk(stl_pkg::K_UNK, 1'b0, 1'b0, 2'd1);
				end
			endcase
		end
		// pack tokens in order, first slot always used first
		if (tp.vld) begin
			t0 = tp; t1 = tf;
		end else begin
			t0 = tf; t1 = '0;
		end
	end

endmodule

FILE: hdl/source_token_lexer.sv
// ----------------------------------------------------------------------------
// source_token_lexer - streaming lexer for a small c-like language
// one source byte per word in, zero to two token words out per byte
// ----------------------------------------------------------------------------
// output: a token word is offered in the cycle after the byte that closes it
// throughput: one byte accepted every cycle while the buffer has space; a byte giving
//   two tokens fills both entries, and input waits while the two-word buffer drains
// reset: arst_n clears mode, counters and buffer; line count restarts at one
// end_of_input (or a zero byte then end_of_input) restores the reset state
module source_token_lexer #(
	parameter int COUNTER_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code [7:0]
	input  logic        s_tuser,   // end_of_input
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // token_kind [5:0], token_line [29:6],
	                               // token_start [53:30], token_length [77:54], zero pad
	output logic        m_tlast    // last_of_run
);
	localparam logic [COUNTER_BITS-1:0] CMAX = '1;
	localparam int WW = 81;

	logic [3:0]              mode_q;
	logic [COUNTER_BITS-1:0] line_q, pos_q, pend_q;
	stl_pkg::kw_win_t        win_q;
	logic                    too_long_q, dot_q;

	logic                    acc, stopped, eoi;
	logic [7:0]              b;
	stl_pkg::tok_ctl_t       t0, t1;
	logic [3:0]              mode_nx;
	logic                    line_inc, set_pend, pend_plus1, too_long_nx, dot_nx;
	stl_pkg::kw_win_t        win_nx;
	logic [COUNTER_BITS-1:0] span, pos_inc, line_nx;
	logic [WW-1:0]           w0, w1, ow;
	logic [1:0]              cnt;
	logic                    space;

	assign acc     = s_tvalid && s_tready;
	assign s_tready = space;
	assign stopped = mode_q == stl_pkg::MD_STOP;
	assign eoi     = s_tuser;
	assign b       = eoi ? 8'd0 : s_tdata;

	stl_scan u_scan (
		.mode(mode_q), .b(b), .win(win_q), .too_long(too_long_q), .dot(dot_q),
		.t0(t0), .t1(t1), .mode_nx(mode_nx), .line_inc(line_inc),
		.set_pend(set_pend), .pend_plus1(pend_plus1), .win_nx(win_nx),
		.too_long_nx(too_long_nx), .dot_nx(dot_nx)
	);

	assign span    = (pos_q >= pend_q) ? pos_q - pend_q : '0;
	assign pos_inc = (pos_q == CMAX) ? CMAX : pos_q + COUNTER_BITS'(1);
	// tokens carry the line count from before this byte's own newline
	assign line_nx = (line_inc && line_q != CMAX) ? line_q + COUNTER_BITS'(1) : line_q;

	function automatic logic [WW-1:0] pack(input stl_pkg::tok_ctl_t t,
			input logic lst, input logic [COUNTER_BITS-1:0] ln,
			input logic [COUNTER_BITS-1:0] p, input logic [COUNTER_BITS-1:0] pd,
			input logic [COUNTER_BITS-1:0] sp);
		logic [COUNTER_BITS-1:0] st, len;
		st  = t.at_pend ? pd : p;
		len = t.len_span ? sp : COUNTER_BITS'(t.len_small);
		return {lst, 2'b00, 24'(len), 24'(st), 24'(ln), t.kind};
	endfunction

	assign w0  = pack(t0, !t1.vld, line_q, pos_q, pend_q, span);
	assign w1  = pack(t1, 1'b1, line_q, pos_q, pend_q, span);
	assign cnt = stopped ? 2'd0 : 2'(t0.vld) + 2'(t1.vld);

	stl_skid #(.W(WW)) u_skid (
		.clk(clk), .arst_n(arst_n), .in_vld(acc), .in_cnt(cnt), .in_w0(w0),
		.in_w1(w1), .space(space), .out_vld(m_tvalid), .out_rdy(m_tready), .out_w(ow)
	);

	assign m_tdata = ow[79:0];
	assign m_tlast = ow[80];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stl_pkg::MD_IDLE;
			line_q <= COUNTER_BITS'(1);
			pos_q <= '0;
			pend_q <= '0;
			win_q <= '0;
			too_long_q <= 1'b0;
			dot_q <= 1'b0;
		end else if (acc) begin
			if (eoi) begin
				// end of input always returns to the reset state
				mode_q <= stl_pkg::MD_IDLE;
				line_q <= COUNTER_BITS'(1);
				pos_q <= '0;
				pend_q <= '0;
				win_q <= '0;
				too_long_q <= 1'b0;
				dot_q <= 1'b0;
			end else if (!stopped) begin
				mode_q <= mode_nx;
				line_q <= line_nx;
				if (mode_nx != stl_pkg::MD_STOP) pos_q <= pos_inc;
				if (set_pend) pend_q <= pend_plus1 ? pos_inc : pos_q;
				win_q <= win_nx;
				too_long_q <= too_long_nx;
				dot_q <= dot_nx;
			end
		end
	end

`ifndef SYNTH
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && stopped) |=> (mode_q == stl_pkg::MD_STOP || mode_q == stl_pkg::MD_IDLE))
		else $error("left stop without end of input");
	a_eoi_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && eoi) |=> (mode_q == stl_pkg::MD_IDLE && pos_q == '0))
		else $error("end of input did not reset");
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0) else $error("line count zero");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		t1.vld |-> t0.vld) else $error("second token without first");
`endif

endmodule

FILE: verif/source_token_lexer_tb.sv
// ----------------------------------------------------------------------------
// source_token_lexer_tb - self-checking bench for the source token lexer
// drives source bytes through a directed table and then random token-shaped
// text, predicts every token word and compares them field by field
// ----------------------------------------------------------------------------
module source_token_lexer_tb;

	localparam int CB = 24;
	localparam longint CMAX = (64'd1 << CB) - 1;
	localparam int LIMIT = 2000000;

	localparam logic [47:0] KW_TEXT [10] = '{
		48'h6D656F77, 48'h696E74, 48'h64656369, 48'h626F6F6C, 48'h63686172,
		48'h737472696E67, 48'h74727565, 48'h66616C7365, 48'h6966, 48'h656C7365
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [23:0] line;
		logic [23:0] start;
		logic [23:0] len;
		logic        last;
	} tok_t;

	typedef struct {
		logic [7:0] ch;
		logic       eoi;
		logic       has_exp;
		tok_t       exp;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        m_tlast;

	source_token_lexer #(.COUNTER_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// predictor state
	logic [3:0]  mode;
	longint      lines, pos, pstart;
	logic [47:0] window;
	logic        too_long, dot;
	tok_t        tokens_due[$];
	tok_t        new_toks[$];

	int  errors = 0;
	int  cycles = 0;
	int  n_sent = 0;
	int  send_idle = 0;   // percent
	int  recv_stall = 0;  // percent
	bit  directed_pin = 0;
	tok_t pin_tok;

	initial clk = 1'b0;

	always #5 clk = ~clk;

	function automatic longint sat_inc(longint v);
		return v >= CMAX ? CMAX : v + 1;
	endfunction

	function automatic bit alpha(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	task automatic scanner_reset();
		mode = stl_pkg::MD_IDLE; lines = 1; pos = 0; pstart = 0;
		window = '0; too_long = 0; dot = 0;
	endtask

	function automatic void emit(logic [5:0] k, longint st, longint ln);
		tok_t t;
		t.kind = k; t.line = lines[23:0]; t.start = st[23:0]; t.len = ln[23:0];
		t.last = 0;
		new_toks.insert(new_toks.size(), t);
	endfunction

	function automatic logic [5:0] keyword_of();
		logic [5:0] k;
		k = stl_pkg::K_IDENT;
		if (!too_long)
			for (int i = 0; i < 10; i++)
				if (window == KW_TEXT[i]) k = 6'(i + 1);
		return k;
	endfunction

	// offer a byte to the open token; returns 1 if it was swallowed
	function automatic bit close_pending(logic [7:0] b);
		logic [3:0] m;
		longint sp;
		m = mode;
		mode = stl_pkg::MD_IDLE;
		sp = pos >= pstart ? pos - pstart : 0;
		case (m)
			stl_pkg::MD_WORD: begin
				if (alpha(b) || digit(b) || b == "_") begin
					if (window[47:40] != 0) too_long = 1;
					else window = {window[39:0], b};
					mode = stl_pkg::MD_WORD;
					return 1;
				end
				emit(keyword_of(), pstart, sp);
			end
			stl_pkg::MD_NUM: begin
				if (digit(b) || (b == "." && !dot)) begin
					if (b == ".") dot = 1;
					mode = stl_pkg::MD_NUM;
					return 1;
				end
				emit(dot ? stl_pkg::K_DEC : stl_pkg::K_INT, pstart, sp);
			end
			stl_pkg::MD_STR: begin
				if (b == 8'h22) begin emit(stl_pkg::K_STR, pstart, sp); return 1; end
				if (b == 0) begin emit(stl_pkg::K_STR, pstart, sp); return 0; end
				if (b == 8'd10) lines = sat_inc(lines);
				mode = stl_pkg::MD_STR;
				return 1;
			end
			stl_pkg::MD_CHOPEN: begin
				if (b == 8'd10 || b == 0) begin emit(stl_pkg::K_CHR, pstart, 0); return 0; end
				mode = stl_pkg::MD_CHGOT;
				return 1;
			end
			stl_pkg::MD_CHGOT: begin
				emit(stl_pkg::K_CHR, pstart, 1);
				return b == 8'h27;
			end
			stl_pkg::MD_EQ: begin
				if (b == "=") begin emit(stl_pkg::K_EQEQ, pstart, 2); return 1; end
				emit(stl_pkg::K_ASSIGN, pstart, 1);
			end
			stl_pkg::MD_BANG: begin
				if (b == "=") begin emit(stl_pkg::K_NE, pstart, 2); return 1; end
				emit(stl_pkg::K_NOT, pstart, 1);
			end
			stl_pkg::MD_LT: begin
				if (b == "<") begin emit(stl_pkg::K_SHL, pstart, 2); return 1; end
				if (b == "=") begin emit(stl_pkg::K_LE, pstart, 2); return 1; end
				emit(stl_pkg::K_LT, pstart, 1);
			end
			stl_pkg::MD_GT: begin
				if (b == "=") begin emit(stl_pkg::K_GE, pstart, 2); return 1; end
				emit(stl_pkg::K_GT, pstart, 1);
			end
			stl_pkg::MD_AMP: begin
				if (b == "&") begin emit(stl_pkg::K_ANDAND, pstart, 2); return 1; end
				emit(stl_pkg::K_UNK, pstart, 1);
			end
			stl_pkg::MD_BAR: begin
				if (b == "|") begin emit(stl_pkg::K_OROR, pstart, 2); return 1; end
				emit(stl_pkg::K_UNK, pstart, 1);
			end
			default: ;
		endcase
		return 0;
	endfunction

	task automatic open_token(logic [7:0] b);
		longint p;
		p = pos;
		case (b)
			8'd0: begin emit(stl_pkg::K_EOF, p, 0); mode = stl_pkg::MD_STOP; end
			8'd10: lines = sat_inc(lines);
			8'd9, 8'd11, 8'd12, 8'd13, " ": ;
			"+": emit(stl_pkg::K_PLUS, p, 1);
			"-": emit(stl_pkg::K_MINUS, p, 1);
			"*": emit(stl_pkg::K_STAR, p, 1);
			"/": emit(stl_pkg::K_SLASH, p, 1);
			"%": emit(stl_pkg::K_PCT, p, 1);
			"(": emit(stl_pkg::K_LPAR, p, 1);
			")": emit(stl_pkg::K_RPAR, p, 1);
			"{": emit(stl_pkg::K_LBR, p, 1);
			"}": emit(stl_pkg::K_RBR, p, 1);
			";": emit(stl_pkg::K_SEMI, p, 1);
			"=": begin mode = stl_pkg::MD_EQ; pstart = p; end
			"!": begin mode = stl_pkg::MD_BANG; pstart = p; end
			"<": begin mode = stl_pkg::MD_LT; pstart = p; end
			">": begin mode = stl_pkg::MD_GT; pstart = p; end
			"&": begin mode = stl_pkg::MD_AMP; pstart = p; end
			"|": begin mode = stl_pkg::MD_BAR; pstart = p; end
			8'h22: begin mode = stl_pkg::MD_STR; pstart = sat_inc(p); end
			8'h27: begin mode = stl_pkg::MD_CHOPEN; pstart = sat_inc(p); end
			default: begin
				if (alpha(b) || b == "_") begin
					mode = stl_pkg::MD_WORD; pstart = p; window = {40'd0, b}; too_long = 0;
				end else if (digit(b)) begin
					mode = stl_pkg::MD_NUM; pstart = p; dot = 0;
				end else emit(stl_pkg::K_UNK, p, 1);
			end
		endcase
	endtask

	// advance the predictor by one accepted word, leaving tokens in new_toks
	task automatic predict_byte(logic [7:0] ch, logic eoi);
		logic [7:0] b;
		new_toks.delete();
		if (mode == stl_pkg::MD_STOP) begin
			if (eoi) scanner_reset();
			return;
		end
		b = eoi ? 8'd0 : ch;
		if (!close_pending(b)) open_token(b);
		if (!eoi && mode != stl_pkg::MD_STOP) pos = sat_inc(pos);
		if (new_toks.size() > 0) new_toks[new_toks.size()-1].last = 1;
		if (eoi) scanner_reset();
	endtask

	// send one word, wait for acceptance, queue the predicted tokens
	task automatic send_byte(logic [7:0] ch, logic eoi);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= ch;
		s_tuser <= eoi;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_byte(ch, eoi);
		foreach (new_toks[i]) tokens_due.insert(tokens_due.size(), new_toks[i]);
		n_sent++;
	endtask

	// token word checking
	always @(posedge clk) begin
		tok_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tdata[5:0];
			got.line = m_tdata[29:6];
			got.start = m_tdata[53:30];
			got.len = m_tdata[77:54];
			got.last = m_tlast;
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected token word kind %0d line %0d start %0d len %0d",
					$time, got.kind, got.line, got.start, got.len);
				errors++;
			end else begin
				want = tokens_due.pop_front();
				if (directed_pin) begin
					if (pin_tok !== want) begin
						$display("%0t: table entry disagrees with prediction exp %h act %h",
							$time, pin_tok, want);
						errors++;
					end
					directed_pin = 0;
				end
				if (got.kind !== want.kind) begin
					$display("%0t: kind exp %0d act %0d", $time, want.kind, got.kind); errors++;
				end
				if (got.line !== want.line) begin
					$display("%0t: line exp %0d act %0d", $time, want.line, got.line); errors++;
				end
				if (got.start !== want.start) begin
					$display("%0t: start exp %0d act %0d", $time, want.start, got.start);
					errors++;
				end
				if (got.len !== want.len) begin
					$display("%0t: length exp %0d act %0d", $time, want.len, got.len); errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last exp %0b act %0b", $time, want.last, got.last); errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
		cycles++;
		if (cycles > LIMIT) begin
			$display("source_token_lexer regression: fail");
			$finish;
		end
	end

	// random token-shaped text
	task automatic send_word();
		int n;
		string kw[10] = '{"meow", "int", "deci", "bool", "char", "string", "true", "false",
			"if", "else"};
		string s;
		n = $urandom_range(5);
		if (n < 2) begin
			s = kw[$urandom_range(9)];
			foreach (s[i]) send_byte(s[i], 0);
		end else begin
			n = $urandom_range(9, 1);
			send_byte($urandom_range(1) ? 8'h5F : 8'("a" + $urandom_range(25)), 0);
			repeat (n - 1) begin
				case ($urandom_range(3))
					0: send_byte(8'("A" + $urandom_range(25)), 0);
					1: send_byte(8'("0" + $urandom_range(9)), 0);
					2: send_byte("_", 0);
					default: send_byte(8'("a" + $urandom_range(25)), 0);
				endcase
			end
		end
	endtask

	task automatic send_random_token();
		string ops[13] = '{"==", "!=", "<=", "<<", ">=", "&&", "||", "=", "!", "<", ">",
			"&", "|"};
		string punct = "+-*/%(){};";
		string s;
		case ($urandom_range(11))
			0, 1: send_word();
			2: repeat ($urandom_range(6, 1))
				send_byte($urandom_range(6) == 0 ? 8'h2E : 8'("0" + $urandom_range(9)), 0);
			3: begin
				send_byte(8'h22, 0);
				repeat ($urandom_range(6)) send_byte(8'($urandom_range(1, 255)), 0);
				if ($urandom_range(3) != 0) send_byte(8'h22, 0);
			end
			4: begin
				send_byte(8'h27, 0);
				send_byte($urandom_range(3) == 0 ? 8'd10 : 8'($urandom_range(1, 255)), 0);
				if ($urandom_range(1)) send_byte(8'h27, 0);
			end
			5, 6: begin
				s = ops[$urandom_range(12)];
				foreach (s[i]) send_byte(s[i], 0);
			end
			7: send_byte(punct[$urandom_range(9)], 0);
			8, 9: send_byte($urandom_range(2) == 0 ? 8'd10 : 8'h20, 0);
			10: send_byte(8'($urandom_range(1, 255)), 0);
			default: begin
				// stream end: sometimes a zero byte and up to two ignored bytes, then end of input
				if ($urandom_range(3) == 0) begin
					send_byte(8'd0, 0);
					repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)), 0);
				end
				send_byte(8'($urandom_range(255)), 1);
			end
		endcase
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic row_t r(logic [7:0] c, logic e);
		row_t x;
		x.ch = c; x.eoi = e; x.has_exp = 0; x.exp = '0;
		return x;
	endfunction

	function automatic row_t rx(logic [7:0] c, logic e, logic [5:0] k, int ln, int st, int len);
		row_t x;
		x = r(c, e);
		x.has_exp = 1;
		x.exp = {k, 24'(ln), 24'(st), 24'(len), 1'b1};
		return x;
	endfunction

	row_t dir_rows[$];

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		m_tready = 1;
		scanner_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table: eof right after reset, operators, literals, stopped state
		dir_rows = '{
			rx(8'h00, 0, stl_pkg::K_EOF, 1, 0, 0),
			r(8'hFF, 0),
			r(8'h00, 1),
			rx(8'h00, 1, stl_pkg::K_EOF, 1, 0, 0),
			r("i", 0), r("f", 0), r(" ", 0),
			rx(8'hFF, 0, stl_pkg::K_UNK, 1, 3, 1),
			r("&", 0), r("|", 0), r("|", 0),
			r("<", 0), r("<", 0), r("!", 0), r("=", 0), r("=", 0), r("3", 0),
			r(".", 0), r("5", 0), r(".", 0),
			r(8'h27, 0), r(8'd10, 0),
			r(8'h22, 0), r("x", 0),
			r(8'h00, 1),
			r("s", 0), r("t", 0), r("r", 0), r("i", 0), r("n", 0), r("g", 0), r("s", 0),
			r(";", 0), r(8'h27, 0), r(8'h27, 0), r(8'h27, 0), r(8'd9, 0),
			r(">", 0), r("=", 0), r(8'h00, 1)
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_exp) begin
				drain();
				pin_tok = dir_rows[i].exp;
				directed_pin = 1;
			end
			send_byte(dir_rows[i].ch, dir_rows[i].eoi);
		end
		drain();

		// random phases with varying back-pressure
		n_sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 84; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 84; end
				default: begin send_idle = 17; recv_stall = 17; end
			endcase
			while (n_sent < 400 * (ph + 1)) begin
				send_random_token();
				if ($urandom_range(60) == 0) drain();
			end
		end
		send_byte(8'h00, 1);

		send_idle = 0;
		recv_stall = 0;
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("source_token_lexer regression: pass");
		else
			$display("source_token_lexer regression: fail");
		$finish;
	end

endmodule
